@@ hw/rtl/ybr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YMODEM block receiver package
// Shared widths, framing codes, state and class types, and the CRC-16 step.
// ----------------------------------------------------------------------------
package ybr_pkg;

   localparam int unsigned CFG_W       = 12;
   localparam int unsigned CNT_W       = 11;
   localparam int unsigned TICK_W      = 12;
   localparam int unsigned CRC_W       = 16;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned CSR_IDX_W   = 1;
   localparam int unsigned RSP_DATA_W  = 32;
   localparam int unsigned REQ_DATA_W  = 8;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BYTE_W-1:0] HDR_SOH    = 8'h01;
   localparam logic [BYTE_W-1:0] HDR_STX    = 8'h02;
   localparam logic [BYTE_W-1:0] HDR_EOT    = 8'h04;
   localparam logic [BYTE_W-1:0] HDR_CAN    = 8'h18;
   localparam logic [BYTE_W-1:0] COMP_MATCH = 8'hFF;

   localparam logic [CRC_W-1:0]  CRC_POLY   = 16'h1021;
   localparam logic [CNT_W-1:0]  SHORT_LEN  = 11'd128;
   localparam logic [CNT_W-1:0]  LONG_LEN   = 11'd1024;
   localparam logic [TICK_W-1:0] TICK_MAX   = 12'hFFF;

   localparam logic [CFG_W-1:0]  HDR_TIMEOUT_RST  = 12'd1500;
   localparam logic [CFG_W-1:0]  BYTE_TIMEOUT_RST = 12'd500;

   localparam logic [CSR_IDX_W-1:0] CSR_HDR_TIMEOUT  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_TIMEOUT = 1'b1;

   typedef enum logic [0:0] {
      OP_BYTE,
      OP_TICK
   } op_type;

   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_SOH,
      CLS_STX,
      CLS_EOT,
      CLS_CAN
   } byte_class_type;

   typedef enum logic [0:0] {
      KIND_PAYLOAD,
      KIND_VERDICT
   } kind_type;

   typedef enum logic [1:0] {
      VERDICT_GOOD,
      VERDICT_END,
      VERDICT_ERROR,
      VERDICT_CANCEL
   } verdict_type;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_CAN2,
      PH_NUM,
      PH_COMP,
      PH_DATA,
      PH_CRCH,
      PH_CRCL
   } phase_type;

   typedef struct packed {
      op_type              op;
      logic [BYTE_W-1:0]   data;
      byte_class_type      cls;
   } queue_entry_type;

   // Result fields in tdata order, payload in the lowest bits.
   typedef struct packed {
      logic [BYTE_W-1:0]   block_number;
      logic [CNT_W-1:0]    block_size;
      verdict_type         verdict;
      logic [BYTE_W-1:0]   payload;
   } result_data_type;

   localparam int unsigned RSP_PAD_W = RSP_DATA_W - $bits(result_data_type);

   // One byte of CRC-16/XMODEM, MSB first.
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ hw/rtl/ybr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YMODEM block receiver front end
// Tags each incoming request with its operation and a framing byte class.
// ----------------------------------------------------------------------------
module ybr_front (
   input  logic                                req_op,
   input  logic [ybr_pkg::BYTE_W-1:0]          req_byte,
   output ybr_pkg::queue_entry_type            entry
);

   ybr_pkg::byte_class_type cls;

   always_comb begin
      unique case (req_byte)
         ybr_pkg::HDR_SOH: cls = ybr_pkg::CLS_SOH;
         ybr_pkg::HDR_STX: cls = ybr_pkg::CLS_STX;
         ybr_pkg::HDR_EOT: cls = ybr_pkg::CLS_EOT;
         ybr_pkg::HDR_CAN: cls = ybr_pkg::CLS_CAN;
         default:          cls = ybr_pkg::CLS_OTHER;
      endcase
   end

   assign entry.op   = ybr_pkg::op_type'(req_op);
   assign entry.data = req_byte;
   assign entry.cls  = cls;

endmodule

@@ hw/rtl/ybr_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YMODEM block receiver request queue
// Short FIFO that decouples the classifier from the deframing engine.
// ----------------------------------------------------------------------------
module ybr_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   output logic                       push_ready,
   input  ybr_pkg::queue_entry_type   push_entry,
   output logic                       pop_valid,
   input  logic                       pop_ready,
   output ybr_pkg::queue_entry_type   pop_entry
);

   ybr_pkg::queue_entry_type            entries_ff [ybr_pkg::QUEUE_DEPTH];
   logic [ybr_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ybr_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [ybr_pkg::QUEUE_CNT_W-1:0]     count_ff, count_in;
   logic                                push, pop;

   assign push_ready = (count_ff != ybr_pkg::QUEUE_CNT_W'(ybr_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entries_ff[rd_ptr_ff];

   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + ybr_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + ybr_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + ybr_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - ybr_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ hw/rtl/ybr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YMODEM block receiver deframing engine
// Runs the block state machine, CRC and timeouts, and holds the result register.
// ----------------------------------------------------------------------------
module ybr_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [ybr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ybr_pkg::CFG_W-1:0]            csr_wdata,
   input  logic                                 entry_valid,
   output logic                                 entry_ready,
   input  ybr_pkg::queue_entry_type             entry,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic                                 rsp_kind,
   output ybr_pkg::result_data_type             rsp_data
);

   logic [ybr_pkg::CFG_W-1:0]    hdr_timeout_ff, byte_timeout_ff;
   ybr_pkg::phase_type           phase_ff, phase_in;
   logic [ybr_pkg::CNT_W-1:0]    byte_count_ff, byte_count_in;
   logic [ybr_pkg::CRC_W-1:0]    crc_ff, crc_in;
   logic [ybr_pkg::BYTE_W-1:0]   crc_high_ff, crc_high_in;
   logic [ybr_pkg::BYTE_W-1:0]   held_number_ff, held_number_in;
   logic                         long_block_ff, long_block_in;
   logic [ybr_pkg::TICK_W-1:0]   tick_ff, tick_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_kind_ff, rsp_kind_in;
   ybr_pkg::result_data_type     rsp_data_ff, rsp_data_in;

   logic                         out_free, take, res_valid, go_header;
   logic [ybr_pkg::CNT_W-1:0]    count_inc, block_len;
   logic [ybr_pkg::TICK_W-1:0]   tick_sat;
   logic [ybr_pkg::CFG_W-1:0]    limit;
   logic                         tick_fire, comp_ok, last_data, crc_ok;
   ybr_pkg::kind_type            res_kind;
   ybr_pkg::result_data_type     res_data;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign entry_ready = out_free;
   assign take        = entry_valid && out_free;

   assign count_inc = byte_count_ff + ybr_pkg::CNT_W'(1);
   assign block_len = long_block_ff ? ybr_pkg::LONG_LEN : ybr_pkg::SHORT_LEN;
   assign last_data = (count_inc >= block_len);
   assign tick_sat  = (tick_ff == ybr_pkg::TICK_MAX) ? tick_ff
                                                      : tick_ff + ybr_pkg::TICK_W'(1);
   assign limit     = (phase_ff == ybr_pkg::PH_HEADER) ? hdr_timeout_ff : byte_timeout_ff;
   assign tick_fire = (tick_sat >= limit);
   assign comp_ok   = ((held_number_ff ^ entry.data) == ybr_pkg::COMP_MATCH);
   assign crc_ok    = ({crc_high_ff, entry.data} == crc_ff);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         if (entry.op == ybr_pkg::OP_TICK) begin
            if (tick_fire) begin
               phase_in = ybr_pkg::PH_HEADER;
            end
         end else begin
            unique case (phase_ff)
               ybr_pkg::PH_HEADER: begin
                  unique case (entry.cls) inside
                     ybr_pkg::CLS_CAN:                  phase_in = ybr_pkg::PH_CAN2;
                     ybr_pkg::CLS_SOH, ybr_pkg::CLS_STX: phase_in = ybr_pkg::PH_NUM;
                     default:                           phase_in = ybr_pkg::PH_HEADER;
                  endcase
               end
               ybr_pkg::PH_CAN2: phase_in = ybr_pkg::PH_HEADER;
               ybr_pkg::PH_NUM:  phase_in = ybr_pkg::PH_COMP;
               ybr_pkg::PH_COMP: phase_in = comp_ok ? ybr_pkg::PH_DATA : ybr_pkg::PH_HEADER;
               ybr_pkg::PH_DATA: phase_in = last_data ? ybr_pkg::PH_CRCH : ybr_pkg::PH_DATA;
               ybr_pkg::PH_CRCH: phase_in = ybr_pkg::PH_CRCL;
               ybr_pkg::PH_CRCL: phase_in = ybr_pkg::PH_HEADER;
               default:          phase_in = ybr_pkg::PH_HEADER;
            endcase
         end
      end
   end

   // Datapath and result for the entry being processed.
   always_comb begin
      byte_count_in  = byte_count_ff;
      crc_in         = crc_ff;
      crc_high_in    = crc_high_ff;
      held_number_in = held_number_ff;
      long_block_in  = long_block_ff;
      tick_in        = tick_ff;
      res_valid      = 1'b0;
      res_kind       = ybr_pkg::KIND_VERDICT;
      res_data       = '0;
      go_header      = 1'b0;

      if (take) begin
         if (entry.op == ybr_pkg::OP_TICK) begin
            tick_in = tick_sat;
            if (tick_fire) begin
               res_valid        = 1'b1;
               res_data.verdict = ybr_pkg::VERDICT_ERROR;
               go_header        = 1'b1;
            end
         end else begin
            tick_in = '0;
            unique case (phase_ff)
               ybr_pkg::PH_HEADER: begin
                  unique case (entry.cls) inside
                     ybr_pkg::CLS_EOT: begin
                        res_valid        = 1'b1;
                        res_data.verdict = ybr_pkg::VERDICT_END;
                        go_header        = 1'b1;
                     end
                     ybr_pkg::CLS_CAN: begin
                     end
                     ybr_pkg::CLS_SOH, ybr_pkg::CLS_STX: begin
                        long_block_in = (entry.cls == ybr_pkg::CLS_STX);
                        byte_count_in = '0;
                        crc_in        = '0;
                     end
                     default: begin
                        res_valid        = 1'b1;
                        res_data.verdict = ybr_pkg::VERDICT_ERROR;
                        go_header        = 1'b1;
                     end
                  endcase
               end
               ybr_pkg::PH_CAN2: begin
                  res_valid        = 1'b1;
                  res_data.verdict = (entry.cls == ybr_pkg::CLS_CAN) ? ybr_pkg::VERDICT_CANCEL
                                                                     : ybr_pkg::VERDICT_ERROR;
                  go_header        = 1'b1;
               end
               ybr_pkg::PH_NUM: begin
                  held_number_in = entry.data;
               end
               ybr_pkg::PH_COMP: begin
                  if (comp_ok) begin
                     byte_count_in = '0;
                  end else begin
                     res_valid        = 1'b1;
                     res_data.verdict = ybr_pkg::VERDICT_ERROR;
                     go_header        = 1'b1;
                  end
               end
               ybr_pkg::PH_DATA: begin
                  crc_in           = ybr_pkg::crc_byte(crc_ff, entry.data);
                  byte_count_in    = count_inc;
                  res_valid        = 1'b1;
                  res_kind         = ybr_pkg::KIND_PAYLOAD;
                  res_data.payload = entry.data;
               end
               ybr_pkg::PH_CRCH: begin
                  crc_high_in = entry.data;
               end
               ybr_pkg::PH_CRCL: begin
                  res_valid = 1'b1;
                  if (crc_ok) begin
                     res_data.verdict      = ybr_pkg::VERDICT_GOOD;
                     res_data.block_size   = block_len;
                     res_data.block_number = held_number_ff;
                  end else begin
                     res_data.verdict = ybr_pkg::VERDICT_ERROR;
                  end
                  go_header = 1'b1;
               end
               default: begin
                  go_header = 1'b1;
               end
            endcase
         end
      end

      // Every verdict returns the block to waiting for a header.
      if (go_header) begin
         byte_count_in = '0;
         crc_in        = '0;
         crc_high_in   = '0;
         tick_in       = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = take && res_valid;
         rsp_kind_in  = res_kind;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_timeout_ff  <= ybr_pkg::HDR_TIMEOUT_RST;
         byte_timeout_ff <= ybr_pkg::BYTE_TIMEOUT_RST;
         phase_ff        <= ybr_pkg::PH_HEADER;
         byte_count_ff   <= '0;
         crc_ff          <= '0;
         crc_high_ff     <= '0;
         held_number_ff  <= '0;
         long_block_ff   <= 1'b0;
         tick_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we && (csr_index == ybr_pkg::CSR_HDR_TIMEOUT)) begin
            hdr_timeout_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == ybr_pkg::CSR_BYTE_TIMEOUT)) begin
            byte_timeout_ff <= csr_wdata;
         end
         phase_ff       <= phase_in;
         byte_count_ff  <= byte_count_in;
         crc_ff         <= crc_in;
         crc_high_ff    <= crc_high_in;
         held_number_ff <= held_number_in;
         long_block_ff  <= long_block_in;
         tick_ff        <= tick_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

@@ hw/rtl/ymodem_block_receiver_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YMODEM block receiver
// Deframes SOH/STX blocks with CRC-16, streaming payload bytes and verdicts.
// ----------------------------------------------------------------------------
// Path: a request is written into the queue, taken from it by the deframing
// engine, and its result is captured in the result register.
// Throughput: one request per cycle unless the result port stalls, set by the
// deframing engine and unrolled byte-wide CRC; a four-entry queue absorbs stalls.
// Reset: synchronous; clears the queue and result register, returns to waiting
// for a header and loads timeouts of 1500 and 500 ticks. No clearing pass.
// ----------------------------------------------------------------------------
module ymodem_block_receiver_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ybr_pkg::REQ_DATA_W-1:0]       req_tdata,   // [7:0] rx_byte
   input  logic                                 req_tuser,   // [0] op
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ybr_pkg::RSP_DATA_W-1:0]       rsp_tdata,   // [7:0] payload, [9:8] verdict,
                                                             // [20:10] block_size,
                                                             // [28:21] block_number
   output logic                                 rsp_tuser,   // [0] kind
   input  logic                                 csr_we,
   input  logic [ybr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ybr_pkg::CFG_W-1:0]            csr_wdata
);

   ybr_pkg::queue_entry_type   front_entry;
   ybr_pkg::queue_entry_type   back_entry;
   logic                       back_valid, back_ready;
   ybr_pkg::result_data_type   rsp_data;

   ybr_front u_front (
      .req_op   (req_tuser),
      .req_byte (req_tdata),
      .entry    (front_entry)
   );

   ybr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_entry (front_entry),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_entry  (back_entry)
   );

   ybr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .entry_valid (back_valid),
      .entry_ready (back_ready),
      .entry       (back_entry),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_kind    (rsp_tuser),
      .rsp_data    (rsp_data)
   );

   assign rsp_tdata = {{ybr_pkg::RSP_PAD_W{1'b0}}, rsp_data};

endmodule

@@ tb/ybr_deframe_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YMODEM block receiver checker
// Watches the request, result and CSR ports, predicts every payload byte and
// block verdict from its own deframer model, and compares results in order.
// ----------------------------------------------------------------------------
module ybr_deframe_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [ybr_pkg::REQ_DATA_W-1:0]    req_tdata,   // [7:0] rx_byte
   input  logic                              req_tuser,   // [0] op
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [ybr_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [7:0] payload, [9:8] verdict,
                                                          // [20:10] block_size,
                                                          // [28:21] block_number
   input  logic                              rsp_tuser,   // [0] kind
   input  logic                              csr_we,
   input  logic [ybr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ybr_pkg::CFG_W-1:0]         csr_wdata,
   output int unsigned                       fail_count,
   output int unsigned                       pending,
   output int unsigned                       payload_bytes,
   output int unsigned                       good_blocks,
   output int unsigned                       other_verdicts
);
   import ybr_pkg::*;

   typedef struct packed {
      kind_type            kind;
      logic [BYTE_W-1:0]   payload;
      verdict_type         verdict;
      logic [CNT_W-1:0]    size;
      logic [BYTE_W-1:0]   number;
   } deframed_t;

   deframed_t           deframed_q[$];

   logic [CFG_W-1:0]    hdr_limit;
   logic [CFG_W-1:0]    byte_limit;
   phase_type           phase;
   logic [CNT_W-1:0]    data_count;
   logic [CRC_W-1:0]    crc_acc;
   logic [BYTE_W-1:0]   crc_high;
   logic [BYTE_W-1:0]   held_number;
   logic                long_blk;
   logic [TICK_W-1:0]   ticks;
   int unsigned         fails = 0;
   int unsigned         n_payload = 0;
   int unsigned         n_good = 0;
   int unsigned         n_other = 0;

   function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      logic             fb;
      c = crc;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         fb = c[CRC_W-1] ^ b[i];
         c = {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
      end
      return c;
   endfunction

   task automatic restart_header();
      phase      = PH_HEADER;
      data_count = '0;
      crc_acc    = '0;
      crc_high   = '0;
      ticks      = '0;
   endtask

   task automatic close_block(input verdict_type v, input logic [CNT_W-1:0] size,
                              input logic [BYTE_W-1:0] num);
      deframed_t r;
      r.kind    = KIND_VERDICT;
      r.payload = '0;
      r.verdict = v;
      r.size    = size;
      r.number  = num;
      deframed_q.push_back(r);
      restart_header();
   endtask

   task automatic deframe_step(input op_type op, input logic [BYTE_W-1:0] b);
      logic [CFG_W-1:0] limit;
      logic [CNT_W-1:0] blk_len;
      deframed_t        r;
      if (op == OP_TICK) begin
         limit = (phase == PH_HEADER) ? hdr_limit : byte_limit;
         if (ticks != TICK_MAX) ticks = ticks + 1'b1;
         // A zero limit is met by the very first tick.
         if (ticks >= limit) close_block(VERDICT_ERROR, '0, '0);
      end else begin
         ticks   = '0;
         blk_len = long_blk ? LONG_LEN : SHORT_LEN;
         case (phase)
            PH_HEADER: begin
               if (b == HDR_EOT) begin
                  close_block(VERDICT_END, '0, '0);
               end else if (b == HDR_CAN) begin
                  phase = PH_CAN2;
               end else if (b == HDR_SOH || b == HDR_STX) begin
                  long_blk   = (b == HDR_STX);
                  data_count = '0;
                  crc_acc    = '0;
                  phase      = PH_NUM;
               end else begin
                  close_block(VERDICT_ERROR, '0, '0);
               end
            end
            PH_CAN2: begin
               close_block((b == HDR_CAN) ? VERDICT_CANCEL : VERDICT_ERROR, '0, '0);
            end
            PH_NUM: begin
               held_number = b;
               phase       = PH_COMP;
            end
            PH_COMP: begin
               if ((held_number ^ b) != COMP_MATCH) begin
                  close_block(VERDICT_ERROR, '0, '0);
               end else begin
                  phase      = PH_DATA;
                  data_count = '0;
               end
            end
            PH_DATA: begin
               crc_acc    = crc_fold(crc_acc, b);
               data_count = data_count + 1'b1;
               if (data_count >= blk_len) phase = PH_CRCH;
               r.kind    = KIND_PAYLOAD;
               r.payload = b;
               r.verdict = VERDICT_GOOD;
               r.size    = '0;
               r.number  = '0;
               deframed_q.push_back(r);
            end
            PH_CRCH: begin
               crc_high = b;
               phase    = PH_CRCL;
            end
            PH_CRCL: begin
               if ({crc_high, b} == crc_acc) begin
                  close_block(VERDICT_GOOD, blk_len, held_number);
               end else begin
                  close_block(VERDICT_ERROR, '0, '0);
               end
            end
            default: restart_header();
         endcase
      end
   endtask

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] seen);
      fails++;
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, seen);
   endtask

   always @(posedge clock) begin
      deframed_t       want;
      result_data_type got;
      if (reset) begin
         deframed_q.delete();
         hdr_limit   = HDR_TIMEOUT_RST;
         byte_limit  = BYTE_TIMEOUT_RST;
         held_number = '0;
         long_blk    = 1'b0;
         restart_header();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_data_type'(rsp_tdata[$bits(result_data_type)-1:0]);
            if (deframed_q.size() == 0) begin
               fails++;
               $display("%0t ns: unexpected result, expected none, got kind %0d data 0x%0h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = deframed_q.pop_front();
               if (rsp_tuser !== want.kind)
                  flag_mismatch("kind", 32'(want.kind), 32'(rsp_tuser));
               if (got.payload !== want.payload)
                  flag_mismatch("payload", 32'(want.payload), 32'(got.payload));
               if (got.verdict !== want.verdict)
                  flag_mismatch("verdict", 32'(want.verdict), 32'(got.verdict));
               if (got.block_size !== want.size)
                  flag_mismatch("block_size", 32'(want.size), 32'(got.block_size));
               if (got.block_number !== want.number)
                  flag_mismatch("block_number", 32'(want.number), 32'(got.block_number));
               if (rsp_tdata[RSP_DATA_W-1 -: RSP_PAD_W] !== '0)
                  flag_mismatch("tdata padding", 32'd0,
                                32'(rsp_tdata[RSP_DATA_W-1 -: RSP_PAD_W]));
               if (want.kind == KIND_PAYLOAD) n_payload++;
               else if (want.verdict == VERDICT_GOOD) n_good++;
               else n_other++;
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_HDR_TIMEOUT) hdr_limit = csr_wdata;
            else byte_limit = csr_wdata;
         end
         if (req_tvalid && req_tready)
            deframe_step(op_type'(req_tuser), req_tdata[BYTE_W-1:0]);
      end
      pending        <= deframed_q.size();
      fail_count     <= fails;
      payload_bytes  <= n_payload;
      good_blocks    <= n_good;
      other_verdicts <= n_other;
   end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YMODEM block receiver testbench
// Drives serial bytes and millisecond ticks through a short directed sequence
// and then randomized good, corrupted and timed-out blocks under several
// timeout settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import ybr_pkg::*;

   localparam int CLOCK_HALF       = 4;
   localparam int RESET_CYCLES     = 3;
   localparam int MAX_GAP          = 15;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int SETTLE_CYCLES    = 8;
   localparam int TAIL_CYCLES      = 16;
   localparam int RANDOM_ITEMS     = 850;
   localparam int LONG_HOLD_CYCLES = 256;
   localparam int HOLD_AT_RESULT   = 150;
   localparam int FAST_TIMEOUT_MAX = 64;

   typedef enum int {
      FLAW_NONE,
      FLAW_COMP,
      FLAW_CRC,
      FLAW_TIMEOUT
   } flaw_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [REQ_DATA_W-1:0]      req_tdata;
   logic                       req_tuser;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RSP_DATA_W-1:0]      rsp_tdata;
   logic                       rsp_tuser;
   logic                       csr_we;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CFG_W-1:0]           csr_wdata;

   int unsigned                fail_count;
   int unsigned                pending;
   int unsigned                payload_bytes;
   int unsigned                good_blocks;
   int unsigned                other_verdicts;

   int                         sent_items = 0;
   int                         settings_used = 0;
   int                         cur_hdr_to;
   int                         cur_byte_to;
   int                         quiet_cycles = 0;
   bit                         req_gaps_on = 1'b1;
   bit                         rsp_gaps_on = 1'b1;

   always #CLOCK_HALF clock = ~clock;

   ymodem_block_receiver_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   ybr_deframe_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending        (pending),
      .payload_bytes  (payload_bytes),
      .good_blocks    (good_blocks),
      .other_verdicts (other_verdicts)
   );

   function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   // Number of ticks that trips a timeout register value.
   function automatic int fire_count(input int limit);
      return (limit == 0) ? 1 : limit;
   endfunction

   task automatic push_request(input op_type op, input logic [7:0] b);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= b;
      sent_items++;
      do begin
         @(posedge clock);
      end while (!req_tready);
   endtask

   task automatic send_ticks(input int count);
      repeat (count) push_request(OP_TICK, 8'($urandom_range(0, 255)));
   endtask

   // Sometimes precedes a byte with a few ticks that stay below the limit.
   task automatic jittered_byte(input logic [7:0] b, input int limit);
      int span;
      span = fire_count(limit) - 1;
      if (span > 3) span = 3;
      if (span > 0 && $urandom_range(0, 7) == 0) send_ticks($urandom_range(1, span));
      push_request(OP_BYTE, b);
   endtask

   task automatic send_block(input bit long_blk, input flaw_type flaw);
      int          len;
      int          last_pos;
      int          stop_at;
      int          pos;
      logic [7:0]  num;
      logic [7:0]  b;
      logic [15:0] crc;
      logic [15:0] crc_flip;
      len      = long_blk ? int'(LONG_LEN) : int'(SHORT_LEN);
      last_pos = len + 4;
      num      = 8'($urandom_range(0, 255));
      crc      = '0;
      crc_flip = (flaw == FLAW_CRC) ? 16'($urandom_range(1, 16'hFFFF)) : 16'h0000;
      stop_at  = (flaw == FLAW_TIMEOUT) ? $urandom_range(0, long_blk ? 20 : len + 3) : -1;
      pos      = 0;
      while (pos <= last_pos) begin
         if (pos == 0) begin
            b = long_blk ? HDR_STX : HDR_SOH;
         end else if (pos == 1) begin
            b = num;
         end else if (pos == 2) begin
            b = (flaw == FLAW_COMP) ? (~num ^ (8'h01 << $urandom_range(0, 7))) : ~num;
         end else if (pos < len + 3) begin
            b   = 8'($urandom_range(0, 255));
            crc = crc16_next(crc, b);
         end else if (pos == len + 3) begin
            crc = crc ^ crc_flip;
            b   = crc[15:8];
         end else begin
            b = crc[7:0];
         end
         jittered_byte(b, (pos == 0) ? cur_hdr_to : cur_byte_to);
         if (pos == stop_at) begin
            send_ticks(fire_count(cur_byte_to));
            pos = last_pos + 1;
         end else if (flaw == FLAW_COMP && pos == 2) begin
            pos = last_pos + 1;
         end else begin
            pos++;
         end
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_timeouts(input int hdr, input int byt);
      drain();
      // Bytes that cause no result may still sit in the block's queue.
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_HDR_TIMEOUT;
      csr_wdata <= CFG_W'(hdr);
      @(negedge clock);
      csr_index <= CSR_BYTE_TIMEOUT;
      csr_wdata <= CFG_W'(byt);
      @(negedge clock);
      csr_we <= 1'b0;
      cur_hdr_to  = hdr;
      cur_byte_to = byt;
      settings_used++;
   endtask

   // Result side: random stalls, plus one long hold-off so the queue fills up.
   initial begin : result_sink
      int stall;
      int taken;
      taken = 0;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = rsp_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
         if (taken == HOLD_AT_RESULT) stall = LONG_HOLD_CYCLES;
         repeat (stall) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do begin
            @(posedge clock);
         end while (!rsp_tvalid);
         taken++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no traffic for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, pending);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int pick;
      int segment;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_BYTE;
      csr_we      = 1'b0;
      csr_index   = CSR_HDR_TIMEOUT;
      csr_wdata   = '0;
      cur_hdr_to  = int'(HDR_TIMEOUT_RST);
      cur_byte_to = int'(BYTE_TIMEOUT_RST);
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Header wait under the reset timeouts: end, cancel, a CAN followed by
      // another byte, garbage at both ends of the byte range, a lone tick, and
      // a block number whose complement does not match.
      push_request(OP_BYTE, HDR_EOT);
      push_request(OP_BYTE, HDR_CAN);
      push_request(OP_BYTE, HDR_CAN);
      push_request(OP_BYTE, HDR_CAN);
      push_request(OP_BYTE, 8'h41);
      push_request(OP_BYTE, 8'h00);
      push_request(OP_BYTE, 8'hFF);
      push_request(OP_TICK, 8'hFF);
      push_request(OP_BYTE, HDR_SOH);
      push_request(OP_BYTE, 8'h00);
      push_request(OP_BYTE, 8'h00);

      // Short timeouts: a header timeout, then a long block that stops after
      // two payload bytes and times out.
      set_timeouts(3, 2);
      send_ticks(3);
      push_request(OP_BYTE, HDR_STX);
      push_request(OP_BYTE, 8'hFF);
      push_request(OP_BYTE, 8'h00);
      push_request(OP_BYTE, 8'h00);
      push_request(OP_BYTE, 8'hFF);
      send_ticks(2);

      segment = 0;
      while (sent_items < RANDOM_ITEMS) begin
         case (segment)
            0:       set_timeouts(4095, 4095);
            1:       set_timeouts(1, 1);
            2:       set_timeouts(0, 0);
            default: set_timeouts(($urandom_range(0, 4) == 0) ? $urandom_range(65, 4095)
                                                              : $urandom_range(2, 24),
                                  ($urandom_range(0, 4) == 0) ? $urandom_range(65, 4095)
                                                              : $urandom_range(2, 24));
         endcase
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         repeat (4) begin
            if (sent_items >= RANDOM_ITEMS) break;
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               send_block(1'b0, FLAW_NONE);
            end else if (pick < 50) begin
               send_block(1'($urandom_range(0, 1)), FLAW_COMP);
            end else if (pick < 60) begin
               send_block(1'b0, FLAW_CRC);
            end else if (pick < 70) begin
               if (fire_count(cur_byte_to) <= FAST_TIMEOUT_MAX)
                  send_block(1'($urandom_range(0, 1)), FLAW_TIMEOUT);
               else
                  send_block(1'b0, FLAW_CRC);
            end else if (pick < 76) begin
               jittered_byte(HDR_EOT, cur_hdr_to);
            end else if (pick < 81) begin
               jittered_byte(HDR_CAN, cur_hdr_to);
               jittered_byte(HDR_CAN, cur_byte_to);
            end else if (pick < 85) begin
               jittered_byte(HDR_CAN, cur_hdr_to);
               jittered_byte(8'($urandom_range(0, 255)), cur_byte_to);
            end else if (pick < 92) begin
               // Idle line: one or two header timeouts when they are reachable.
               if (fire_count(cur_hdr_to) <= FAST_TIMEOUT_MAX)
                  send_ticks(fire_count(cur_hdr_to) * $urandom_range(1, 2));
               else
                  send_ticks($urandom_range(1, 3));
            end else begin
               repeat ($urandom_range(1, 3)) push_request(OP_BYTE, 8'($urandom_range(0, 255)));
            end
         end
         segment++;
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d requests under %0d timeout settings, mixing clean and damaged blocks.",
               sent_items, settings_used + 1);
      $display("Checked %0d payload bytes, %0d good blocks and %0d other verdicts.",
               payload_bytes, good_blocks, other_verdicts);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
